FILE: rtl/core/line_substring_filter_core_assert.svh
// assertion macros of the line substring filter checker
`ifndef LINE_SUBSTRING_FILTER_CORE_ASSERT_SVH
`define LINE_SUBSTRING_FILTER_CORE_ASSERT_SVH

// same-cycle implication, off while reset is active
`define LSF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lsf check failed");

// next-cycle implication, off while reset is active
`define LSF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lsf check failed");

// next-cycle implication that also runs through reset
`define LSF_ASSERT_RST(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("lsf reset check failed");

`endif

FILE: rtl/core/lsf_pkg.sv
// types, constants and helper functions of the line substring filter
`timescale 1ns / 1ps

package lsf_pkg;

    // bytes held by the pattern registers
    localparam int PAT_STORE = 16;

    // ascii codes for case folding
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_PATTERN_WORD0 = 3'd0,
        REG_PATTERN_WORD1 = 3'd1,
        REG_PATTERN_WORD2 = 3'd2,
        REG_PATTERN_WORD3 = 3'd3,
        REG_PATTERN_LENGTH = 3'd4,
        REG_CASE_FOLD = 3'd5,
        REG_INVERT_SELECT = 3'd6
    } t_reg_idx;

    typedef logic [PAT_STORE-1:0][7:0] t_pattern;

    // configuration seen by the datapath
    typedef struct packed {
        t_pattern   pattern;
        logic [4:0] pattern_length;
        logic       case_fold;
        logic       invert_select;
    } t_cfg;

    // input item
    typedef struct packed {
        logic [7:0] text_byte;
        logic       first_of_file;
        logic       last_of_line;
    } t_in;

    // result item
    typedef struct packed {
        logic        line_selected;
        logic        pattern_found;
        logic [31:0] line_no;
    } t_out;

    // fold ascii upper case to lower case when enabled
    function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
        logic [7:0] r;
        r = c;
        if (en && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            r = c - CHAR_UPPER_A + CHAR_LOWER_A;
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/lsf_cfg_regs.sv
// apb configuration registers of the line substring filter
`timescale 1ns / 1ps

module lsf_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output lsf_pkg::t_cfg o_cfg
);

    logic [3:0][31:0] r_pat_words;
    logic [4:0]       r_pattern_length;
    logic             r_case_fold;
    logic             r_invert_select;
    logic             wr_en;
    lsf_pkg::t_reg_idx reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = lsf_pkg::t_reg_idx'(paddr[4:2]);

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_words      <= '0;
            r_pattern_length <= '0;
            r_case_fold      <= 1'b0;
            r_invert_select  <= 1'b0;
        end else if (wr_en) begin
            unique case (reg_idx)
                lsf_pkg::REG_PATTERN_WORD0:  r_pat_words[0] <= pwdata;
                lsf_pkg::REG_PATTERN_WORD1:  r_pat_words[1] <= pwdata;
                lsf_pkg::REG_PATTERN_WORD2:  r_pat_words[2] <= pwdata;
                lsf_pkg::REG_PATTERN_WORD3:  r_pat_words[3] <= pwdata;
                lsf_pkg::REG_PATTERN_LENGTH: r_pattern_length <= pwdata[4:0];
                lsf_pkg::REG_CASE_FOLD:      r_case_fold <= pwdata[0];
                lsf_pkg::REG_INVERT_SELECT:  r_invert_select <= pwdata[0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (reg_idx)
            lsf_pkg::REG_PATTERN_WORD0:  prdata = r_pat_words[0];
            lsf_pkg::REG_PATTERN_WORD1:  prdata = r_pat_words[1];
            lsf_pkg::REG_PATTERN_WORD2:  prdata = r_pat_words[2];
            lsf_pkg::REG_PATTERN_WORD3:  prdata = r_pat_words[3];
            lsf_pkg::REG_PATTERN_LENGTH: prdata = {27'd0, r_pattern_length};
            lsf_pkg::REG_CASE_FOLD:      prdata = {31'd0, r_case_fold};
            lsf_pkg::REG_INVERT_SELECT:  prdata = {31'd0, r_invert_select};
            default:                     prdata = '0;
        endcase
    end

    // byte k of word w lands at pattern byte 4*w+k
    assign o_cfg.pattern        = r_pat_words;
    assign o_cfg.pattern_length = r_pattern_length;
    assign o_cfg.case_fold      = r_case_fold;
    assign o_cfg.invert_select  = r_invert_select;

endmodule

FILE: rtl/core/lsf_match.sv
// window against pattern compare for every candidate length
`timescale 1ns / 1ps

module lsf_match #(
    parameter int DEPTH = 16,
    localparam int LW = $clog2(DEPTH + 1)
) (
    input  logic [DEPTH-1:0][7:0] i_window,
    input  lsf_pkg::t_pattern     i_pattern,
    input  logic                  i_case_fold,
    input  logic [LW-1:0]         i_length,
    input  logic [LW-1:0]         i_fill,
    output logic                  o_hit
);

    logic [DEPTH-1:0][7:0] win_f;
    logic [DEPTH-1:0][7:0] pat_f;
    logic [DEPTH-1:0]      len_match;
    logic [DEPTH-1:0]      len_sel;

    // folded copies of both sides
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            win_f[i] = lsf_pkg::fold_byte(i_window[i], i_case_fold);
            pat_f[i] = lsf_pkg::fold_byte(i_pattern[i], i_case_fold);
        end
    end

    // pattern byte j sits against window slot l-1-j, newest byte last
    always_comb begin
        for (int l = 1; l <= DEPTH; l++) begin
            len_match[l-1] = 1'b1;
            len_sel[l-1]   = (i_length == LW'(l));
            for (int j = 0; j < l; j++) begin
                if (win_f[l-1-j] != pat_f[j]) begin
                    len_match[l-1] = 1'b0;
                end
            end
        end
    end

    // empty pattern always hits, otherwise the line must hold the whole pattern
    assign o_hit = (i_length == '0) || ((i_fill >= i_length) && (|(len_match & len_sel)));

endmodule

FILE: rtl/core/line_substring_filter_core.sv
// top level of the line substring filter: input stage, line state and result stage
// result path: the input register, then the result register
// throughput: one byte per cycle while o_in_stall is low; the compare of all
// alignments is combinational logic between the input and result registers
// input stall rises only while a finished line result waits on a stalled output
// reset: synchronous active low, clears valids, line state, line counter and registers
`timescale 1ns / 1ps

module line_substring_filter_core #(
    parameter int PATTERN_MAX = 16,
    parameter int LINE_COUNT_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  lsf_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output lsf_pkg::t_out o_out_data,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int WIN_DEPTH = (PATTERN_MAX < lsf_pkg::PAT_STORE) ? PATTERN_MAX
                                                                  : lsf_pkg::PAT_STORE;
    localparam int LW = $clog2(WIN_DEPTH + 1);

    lsf_pkg::t_cfg cfg;

    logic                       r_s1_valid;
    lsf_pkg::t_in               r_s1;
    logic [WIN_DEPTH-1:0][7:0]  r_window;
    logic [LW-1:0]              r_fill;
    logic                       r_found;
    logic [LINE_COUNT_BITS-1:0] r_line_cnt;
    logic                       r_out_valid;
    lsf_pkg::t_out              r_out;

    logic [WIN_DEPTH-1:0][7:0]  n_window;
    logic [LW-1:0]              n_fill;
    logic [LINE_COUNT_BITS-1:0] n_line_cnt;
    logic [LW-1:0]              fill_base;
    logic [LINE_COUNT_BITS-1:0] cnt_base;
    logic [LW-1:0]              eff_len;
    logic                       found_base;
    logic                       found_now;
    logic                       hit;
    logic                       out_free;
    logic                       s1_go;
    logic                       emit;
    logic                       in_accept;

    lsf_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // handshake between the two stages
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_go      = r_s1_valid && (!r_s1.last_of_line || out_free);
    assign emit       = s1_go && r_s1.last_of_line;
    assign o_in_stall = r_s1_valid && !s1_go;
    assign in_accept  = i_in_valid && !o_in_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_accept || (r_s1_valid && !s1_go);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1 <= i_in_data;
        end
    end

    // a new file drops the open line and restarts numbering
    always_comb begin
        fill_base  = r_s1.first_of_file ? '0 : r_fill;
        found_base = r_s1.first_of_file ? 1'b0 : r_found;
        cnt_base   = r_s1.first_of_file ? '0 : r_line_cnt;
        n_fill     = (fill_base == LW'(WIN_DEPTH)) ? fill_base : fill_base + LW'(1);
        n_line_cnt = (&cnt_base) ? cnt_base : cnt_base + LINE_COUNT_BITS'(1);
        eff_len    = (cfg.pattern_length > 5'(WIN_DEPTH)) ? LW'(WIN_DEPTH)
                                                          : cfg.pattern_length[LW-1:0];
    end

    // window shift, newest byte in slot zero
    always_comb begin
        n_window[0] = r_s1.text_byte;
        for (int i = 1; i < WIN_DEPTH; i++) begin
            n_window[i] = r_window[i-1];
        end
    end

    lsf_match #(
        .DEPTH (WIN_DEPTH)
    ) u_match (
        .i_window    (n_window),
        .i_pattern   (cfg.pattern),
        .i_case_fold (cfg.case_fold),
        .i_length    (eff_len),
        .i_fill      (n_fill),
        .o_hit       (hit)
    );

    assign found_now = found_base || hit;

    // line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_found    <= 1'b0;
            r_line_cnt <= '0;
        end else if (s1_go) begin
            if (r_s1.last_of_line) begin
                r_fill     <= '0;
                r_found    <= 1'b0;
                r_line_cnt <= n_line_cnt;
            end else begin
                r_fill     <= n_fill;
                r_found    <= found_now;
                r_line_cnt <= cnt_base;
            end
        end
    end

    // only slots below the fill count are ever compared, so no clear is needed
    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_window <= n_window;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= emit || (r_out_valid && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out.line_selected <= found_now ^ cfg.invert_select;
            r_out.pattern_found <= found_now;
            r_out.line_no       <= 32'(n_line_cnt);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: rtl/core/lsf_checker.sv
// port level checks of the line substring filter and their binding
`timescale 1ns / 1ps
`include "line_substring_filter_core_assert.svh"

module lsf_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input lsf_pkg::t_out o_out_data
);

    // both stages come out of reset empty
    `LSF_ASSERT_RST(a_reset_empty, i_clk, !i_rst_n, !o_out_valid && !o_in_stall)

    // input backs up only behind a blocked result
    `LSF_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall)

    // line numbers count from one
    `LSF_ASSERT_IMP(a_line_nonzero, i_clk, i_rst_n, o_out_valid, o_out_data.line_no != 32'd0)

    // a held result stays put
    `LSF_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))

endmodule

bind line_substring_filter_core lsf_checker u_lsf_checker (.*);

FILE: sim/testbench.sv
// self-checking testbench of the line substring filter core: random lines against a scoreboard
`timescale 1ns / 1ps

module testbench;

    localparam int PATTERN_MAX = 16;
    localparam int LINE_COUNT_BITS = 32;
    localparam int PAT_LIMIT = (PATTERN_MAX < lsf_pkg::PAT_STORE) ? PATTERN_MAX
                                                                  : lsf_pkg::PAT_STORE;
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_REPORTS = 10;
    localparam int RANDOM_PHASES = 6;
    localparam int ITEMS_PER_PHASE = 75;
    localparam int MAX_LINE_BYTES = 24;
    // one word past the last register, writes there must be ignored
    localparam logic [4:0] UNUSED_ADDR = 5'd28;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_in_valid = 1'b0;
    logic          o_in_stall;
    lsf_pkg::t_in  i_in_data = '0;
    logic          o_out_valid;
    logic          i_out_stall = 1'b0;
    lsf_pkg::t_out o_out_data;
    logic          psel = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite = 1'b0;
    logic [4:0]    paddr = '0;
    logic [31:0]   pwdata = '0;
    logic [31:0]   prdata;
    logic          pready;

    // idle rates in percent for both sides
    int unsigned send_idle_pct = 34;
    int unsigned recv_idle_pct = 74;

    // bytes waiting to be sent and line results waiting to arrive
    lsf_pkg::t_in  pending_bytes[$];
    lsf_pkg::t_out expected_lines[$];
    int unsigned   line_mismatches = 0;
    lsf_pkg::t_out next_line;

    // register copies
    lsf_pkg::t_pattern pat_cfg = '0;
    logic [4:0]        len_cfg = '0;
    logic              fold_cfg = 1'b0;
    logic              invert_cfg = 1'b0;

    // line state copies
    logic [7:0]                 win [PATTERN_MAX];
    int unsigned                line_bytes = 0;
    logic                       seen_in_line = 1'b0;
    logic [LINE_COUNT_BITS-1:0] line_count = '0;

    line_substring_filter_core #(
        .PATTERN_MAX(PATTERN_MAX),
        .LINE_COUNT_BITS(LINE_COUNT_BITS)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in_data(i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data(o_out_data),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #5 i_clk = ~i_clk;

    // ascii upper to lower when folding is on
    function automatic logic [7:0] to_lower(input logic [7:0] c);
        if (fold_cfg && c >= lsf_pkg::CHAR_UPPER_A && c <= lsf_pkg::CHAR_UPPER_Z) begin
            return c - lsf_pkg::CHAR_UPPER_A + lsf_pkg::CHAR_LOWER_A;
        end
        return c;
    endfunction

    // swap the case of a letter, other bytes unchanged
    function automatic logic [7:0] flip_case(input logic [7:0] c);
        if ((c >= lsf_pkg::CHAR_UPPER_A && c <= lsf_pkg::CHAR_UPPER_Z) ||
            (c >= lsf_pkg::CHAR_LOWER_A && c <= lsf_pkg::CHAR_LOWER_A + 8'd25)) begin
            return c ^ 8'h20;
        end
        return c;
    endfunction

    function automatic void clear_line();
        for (int i = 0; i < PATTERN_MAX; i++) begin
            win[i] = 8'h00;
        end
        line_bytes = 0;
        seen_in_line = 1'b0;
    endfunction

    // advance the line state by one byte, queue the line result on its last byte
    function automatic void filter_byte(input lsf_pkg::t_in item);
        int unsigned   plen;
        logic          hit;
        lsf_pkg::t_out res;
        plen = (len_cfg > PAT_LIMIT) ? PAT_LIMIT : len_cfg;
        if (item.first_of_file) begin
            clear_line();
            line_count = '0;
        end
        for (int i = PATTERN_MAX - 1; i > 0; i--) begin
            win[i] = win[i-1];
        end
        win[0] = item.text_byte;
        if (line_bytes < PATTERN_MAX) begin
            line_bytes++;
        end
        // newest byte sits in slot 0, so pattern byte j faces slot plen-1-j
        hit = 1'b1;
        if (plen != 0) begin
            if (line_bytes < plen) begin
                hit = 1'b0;
            end else begin
                for (int j = 0; j < plen; j++) begin
                    if (to_lower(win[plen-1-j]) != to_lower(pat_cfg[j])) begin
                        hit = 1'b0;
                    end
                end
            end
        end
        if (hit) begin
            seen_in_line = 1'b1;
        end
        if (item.last_of_line) begin
            if (line_count != '1) begin
                line_count++;
            end
            res.line_selected = seen_in_line ^ invert_cfg;
            res.pattern_found = seen_in_line;
            res.line_no = 32'(line_count);
            expected_lines.push_back(res);
            clear_line();
        end
    endfunction

    function automatic logic [4:0] reg_addr(input lsf_pkg::t_reg_idx r);
        return {r, 2'b00};
    endfunction

    // apb write: setup cycle, then access cycle until pready
    task automatic write_reg(input logic [4:0] addr, input logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        // mirror the write into the register copies
        if (addr[1:0] == 2'b00) begin
            case (addr[4:2])
                lsf_pkg::REG_PATTERN_WORD0, lsf_pkg::REG_PATTERN_WORD1,
                lsf_pkg::REG_PATTERN_WORD2, lsf_pkg::REG_PATTERN_WORD3: begin
                    pat_cfg[4*addr[4:2] +: 4] = value;
                end
                lsf_pkg::REG_PATTERN_LENGTH: begin
                    len_cfg = value[4:0];
                end
                lsf_pkg::REG_CASE_FOLD: begin
                    fold_cfg = value[0];
                end
                lsf_pkg::REG_INVERT_SELECT: begin
                    invert_cfg = value[0];
                end
                default: begin
                end
            endcase
        end
    endtask

    // full register set, unused upper bits of the narrow registers left random
    task automatic set_config(input lsf_pkg::t_pattern p, input logic [4:0] len,
                              input logic fold, input logic inv);
        for (int k = 0; k < 4; k++) begin
            write_reg(reg_addr(lsf_pkg::t_reg_idx'(k)), p[4*k +: 4]);
        end
        write_reg(reg_addr(lsf_pkg::REG_PATTERN_LENGTH), ($urandom() & ~32'h1F) | 32'(len));
        write_reg(reg_addr(lsf_pkg::REG_CASE_FOLD), ($urandom() & ~32'h1) | 32'(fold));
        write_reg(reg_addr(lsf_pkg::REG_INVERT_SELECT), ($urandom() & ~32'h1) | 32'(inv));
        write_reg(UNUSED_ADDR, $urandom());
    endtask

    // all bytes sent, all line results back, then the pipeline latency
    task automatic wait_drained();
        while (pending_bytes.size() != 0 || i_in_valid || expected_lines.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic push_byte(input logic [7:0] b, input logic first, input logic last);
        lsf_pkg::t_in item;
        item.text_byte = b;
        item.first_of_file = first;
        item.last_of_line = last;
        pending_bytes.push_back(item);
    endtask

    // one line, often holding the pattern, filler drawn mostly from pattern bytes
    task automatic push_random_line(output int unsigned n);
        int unsigned plen;
        int unsigned at;
        logic        embed;
        logic [7:0]  b;
        plen = (len_cfg > PAT_LIMIT) ? PAT_LIMIT : len_cfg;
        n = $urandom_range(1, MAX_LINE_BYTES);
        embed = ($urandom_range(0, 1) == 1) && (n >= plen) && (plen != 0);
        at = (n > plen) ? $urandom_range(0, n - plen) : 0;
        for (int i = 0; i < n; i++) begin
            if (embed && i >= at && i < at + plen) begin
                b = pat_cfg[i - at];
                if (fold_cfg && $urandom_range(0, 1) == 1) begin
                    b = flip_case(b);
                end
                // near miss
                if ($urandom_range(0, 15) == 0) begin
                    b = b ^ (8'h01 << $urandom_range(0, 7));
                end
            end else if ($urandom_range(0, 3) != 0) begin
                b = pat_cfg[$urandom_range(0, lsf_pkg::PAT_STORE - 1)];
                if ($urandom_range(0, 1) == 1) begin
                    b = flip_case(b);
                end
            end else begin
                b = 8'($urandom_range(0, 255));
            end
            push_byte(b, (i == 0) && ($urandom_range(0, 7) == 0), i == n - 1);
        end
    endtask

    // driver: next byte when the current one is taken or none is out
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                filter_byte(i_in_data);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_data <= pending_bytes.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each taken result with the oldest expected line
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_lines.size() == 0) begin
                    line_mismatches++;
                    if (line_mismatches <= MAX_REPORTS) begin
                        $display("unexpected result: selected %0b found %0b line %0d",
                                 o_out_data.line_selected, o_out_data.pattern_found,
                                 o_out_data.line_no);
                    end
                end else begin
                    next_line = expected_lines.pop_front();
                    if (o_out_data.line_selected !== next_line.line_selected ||
                        o_out_data.pattern_found !== next_line.pattern_found ||
                        o_out_data.line_no !== next_line.line_no) begin
                        line_mismatches++;
                        if (line_mismatches <= MAX_REPORTS) begin
                            $display("line mismatch: expected %0b %0b %0d, got %0b %0b %0d",
                                     next_line.line_selected, next_line.pattern_found,
                                     next_line.line_no, o_out_data.line_selected,
                                     o_out_data.pattern_found, o_out_data.line_no);
                        end
                    end
                end
            end
            i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // stimulus sequence
    initial begin
        lsf_pkg::t_pattern pat;
        logic [4:0]        plen;
        int unsigned       pushed;
        int unsigned       n;
        int unsigned       burst;
        clear_line();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty pattern after reset, byte extremes, new file mid-line
        push_byte(8'h00, 1'b1, 1'b1);
        push_byte(8'hFF, 1'b0, 1'b1);
        push_byte(lsf_pkg::CHAR_UPPER_A, 1'b0, 1'b0);
        push_byte(lsf_pkg::CHAR_UPPER_Z, 1'b1, 1'b1);
        wait_drained();

        // two byte pattern with folding and invert
        pat = '1;
        pat[0] = lsf_pkg::CHAR_LOWER_A;
        pat[1] = lsf_pkg::CHAR_UPPER_A + 8'd1;
        set_config(pat, 5'd2, 1'b1, 1'b1);
        // line shorter than the pattern
        push_byte(lsf_pkg::CHAR_UPPER_A, 1'b1, 1'b1);
        // folded match
        push_byte(8'h78, 1'b0, 1'b0);
        push_byte(lsf_pkg::CHAR_UPPER_A, 1'b0, 1'b0);
        push_byte(lsf_pkg::CHAR_LOWER_A + 8'd1, 1'b0, 1'b1);
        // neighbors of the letter range
        push_byte(lsf_pkg::CHAR_UPPER_A - 8'd1, 1'b0, 1'b0);
        push_byte(lsf_pkg::CHAR_UPPER_Z + 8'd1, 1'b0, 1'b1);
        // bytes above 127 are not folded
        push_byte(lsf_pkg::CHAR_LOWER_A | 8'h80, 1'b0, 1'b0);
        push_byte(lsf_pkg::CHAR_UPPER_A + 8'd1, 1'b0, 1'b1);
        // register writes in the middle of a line
        push_byte(lsf_pkg::CHAR_LOWER_A, 1'b0, 1'b0);
        wait_drained();
        write_reg(reg_addr(lsf_pkg::REG_CASE_FOLD), 32'd0);
        write_reg(reg_addr(lsf_pkg::REG_INVERT_SELECT), 32'd0);
        push_byte(lsf_pkg::CHAR_LOWER_A + 8'd1, 1'b0, 1'b1);
        wait_drained();

        // oversized length acts as the full store, a short line holding its head misses
        for (int i = 0; i < lsf_pkg::PAT_STORE; i++) begin
            pat[i] = lsf_pkg::CHAR_LOWER_A + 8'($urandom_range(0, 2));
        end
        set_config(pat, 5'd20, 1'b0, 1'b0);
        for (int i = 0; i < 4; i++) begin
            push_byte(pat[i], i == 0, i == 3);
        end
        wait_drained();

        // random phases over lengths, folding, invert and idle rates
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: plen = 5'd0;
                1: plen = 5'd1;
                2: plen = 5'd16;
                3: plen = 5'd31;
                4: plen = 5'($urandom_range(2, 8));
                default: plen = 5'($urandom_range(0, 31));
            endcase
            for (int i = 0; i < lsf_pkg::PAT_STORE; i++) begin
                if ($urandom_range(0, 7) == 0) begin
                    pat[i] = 8'($urandom_range(0, 255));
                end else begin
                    pat[i] = (($urandom_range(0, 1) == 1) ? lsf_pkg::CHAR_UPPER_A
                                                          : lsf_pkg::CHAR_LOWER_A)
                             + 8'($urandom_range(0, 2));
                end
            end
            if (ph < 2) begin
                send_idle_pct = 34;
                recv_idle_pct = 74;
            end else if (ph < 4) begin
                send_idle_pct = 74;
                recv_idle_pct = 34;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            wait_drained();
            set_config(pat, plen, 1'(ph % 2), 1'((ph / 2) % 2));
            pushed = 0;
            while (pushed < ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 99) < 85) begin
                    push_random_line(n);
                    pushed += n;
                end else begin
                    // noise: any byte, any flags
                    burst = $urandom_range(1, 4);
                    for (int k = 0; k < burst; k++) begin
                        push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                                  $urandom_range(0, 3) == 0);
                    end
                    pushed += burst;
                end
                // sender holds off mid-phase until every line result is back
                if (pushed >= ITEMS_PER_PHASE / 2 && pushed - n < ITEMS_PER_PHASE / 2) begin
                    wait_drained();
                end
            end
        end

        wait_drained();
        if (line_mismatches == 0 && expected_lines.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
